// ===== design/swtb_pkg.sv =====
package swtb_pkg;

    localparam int MAX_BUCKETS_DEF = 64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SECONDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS_IN_USE = 1'b1;

    localparam logic [15:0] BUCKET_SECONDS_RST = 16'd1;
    localparam logic [6:0]  BUCKETS_IN_USE_RST = 7'd64;

    localparam logic ST_COUNTED = 1'b0;
    localparam logic ST_TOO_OLD = 1'b1;

    typedef struct packed {
        logic [31:0]        event_time;
        logic               use_default;
        logic signed [15:0] add_amount;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [5:0]         bucket_index;
        logic signed [31:0] count_after;
        logic [6:0]         buckets_dropped;
        logic [31:0]        oldest_start;
    } t_out;

    typedef struct packed {
        logic [15:0] bucket_seconds;
        logic [6:0]  buckets_in_use;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

// ===== design/sliding_window_time_bucket_counter.sv =====
// Sliding-window time-bucket counter.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one event: time,
// default flag and amount. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns one result per event: status, bucket position, count
// after the add, buckets dropped and the start of the oldest bucket.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// An event older than the window start gives its result without division; any
// other event passes the bit-serial divider, then clears each dropped
// bucket, one ring entry per cycle through the single memory write port. One
// event is in work at a time: a new event is taken only after the last result
// has left the core. Reset clears the window start and head, loads the register
// defaults, and then sweeps the count memory to zero, one entry a cycle, while
// o_in_ready stays low.
// A result sits in an output register; while the receiver stalls the block
// still takes and works on the next event, and holds its result until the
// output register frees.
module sliding_window_time_bucket_counter #(
    parameter int MAX_BUCKETS = swtb_pkg::MAX_BUCKETS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swtb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swtb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  swtb_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output swtb_pkg::t_out                    o_out_data
);

    localparam int NCAP = (MAX_BUCKETS > 127) ? 127 : MAX_BUCKETS;

    logic [15:0]        r_bsec;
    logic [6:0]         r_biu;
    swtb_pkg::t_cfg     w_cfg;
    swtb_pkg::t_div_req w_div_req;
    swtb_pkg::t_div_rsp w_div_rsp;
    logic               w_res_valid;
    logic               w_res_ready;
    swtb_pkg::t_out     w_res;
    logic               r_out_valid;
    swtb_pkg::t_out     r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsec <= swtb_pkg::BUCKET_SECONDS_RST;
            r_biu  <= swtb_pkg::BUCKETS_IN_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swtb_pkg::CFG_BUCKET_SECONDS: r_bsec <= i_cfg_data;
                swtb_pkg::CFG_BUCKETS_IN_USE: r_biu  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.bucket_seconds = r_bsec;
    assign w_cfg.buckets_in_use = r_biu;

    swtb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    swtb_core #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

    // output register, refilled on the cycle it drains
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_valid && w_res_ready) r_out <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a transfer");

    a_too_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == swtb_pkg::ST_TOO_OLD) |->
        (o_out_data.count_after == 32'sd0 && o_out_data.buckets_dropped == 7'd0 &&
         o_out_data.bucket_index == 6'd0))
        else $error("dropped event carries nonzero fields");

    a_drop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.buckets_dropped <= 7'(NCAP)))
        else $error("more buckets dropped than the window holds");

endmodule

// ===== design/swtb_div.sv =====
module swtb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swtb_pkg::t_div_req i_req,
    output swtb_pkg::t_div_rsp o_rsp
);

    // restoring division, one quotient bit per cycle
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_quo, n_quo;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_div, n_div;
    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[31]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_quo  = i_req.dividend;
            n_rem  = 16'd0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[15:0] : w_trial[15:0];
            n_quo = {r_quo[30:0], w_ge};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== design/swtb_core.sv =====
module swtb_core #(
    parameter int MAX_BUCKETS = swtb_pkg::MAX_BUCKETS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swtb_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  swtb_pkg::t_in      i_in_data,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output swtb_pkg::t_out     o_res,
    output swtb_pkg::t_div_req o_div_req,
    input  swtb_pkg::t_div_rsp i_div_rsp
);

    localparam int AW   = $clog2(MAX_BUCKETS);
    localparam int SW   = ((AW > 7) ? AW : 7) + 1;
    localparam int NCAP = (MAX_BUCKETS > 127) ? 127 : MAX_BUCKETS;
    localparam logic [6:0]    N_CAP = 7'(NCAP);
    localparam logic [AW-1:0] LAST  = AW'(MAX_BUCKETS - 1);

    typedef enum logic [9:0] {
        S_INIT = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_DIV  = 10'b0000000100,
        S_PLAN = 10'b0000001000,
        S_MUL  = 10'b0000010000,
        S_MOVE = 10'b0000100000,
        S_ZERO = 10'b0001000000,
        S_READ = 10'b0010000000,
        S_ADD  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    // ring slot of a window position; base and offset both stay below the ring size
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base, input logic [6:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(MAX_BUCKETS)) sum = sum - SW'(MAX_BUCKETS);
        return sum[AW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [31:0]    r_mem [MAX_BUCKETS];
    logic [31:0]    r_rdata;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [31:0]    w_wdata;
    logic [AW-1:0]  w_raddr;

    logic [AW-1:0]  r_clr;
    logic [31:0]    r_ws;
    logic [AW-1:0]  r_head;
    logic [31:0]    r_when;
    logic [31:0]    r_amount;
    logic [15:0]    r_secs;
    logic [6:0]     r_n;
    logic [31:0]    r_quo;
    logic [6:0]     r_d;
    logic           r_full;
    logic [6:0]     r_pos;
    logic [22:0]    r_prod;
    logic [6:0]     r_zoff;
    logic [6:0]     r_zleft;
    logic [AW-1:0]  r_slot;
    swtb_pkg::t_out r_res;

    logic           w_accept;
    logic           w_too_old;
    logic [15:0]    w_secs;
    logic [6:0]     w_n;
    logic [31:0]    w_nn;
    logic [31:0]    w_s;
    logic [31:0]    w_sum;
    logic [6:0]     w_d;
    logic           w_full;
    logic [6:0]     w_pos;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_too_old   = (i_in_data.event_time < r_ws);

    always_comb begin
        w_secs = (i_cfg.bucket_seconds == 16'd0) ? 16'd1 : i_cfg.bucket_seconds;
        if (i_cfg.buckets_in_use == 7'd0) begin
            w_n = 7'd1;
        end else if (i_cfg.buckets_in_use > N_CAP) begin
            w_n = N_CAP;
        end else begin
            w_n = i_cfg.buckets_in_use;
        end
    end

    assign o_div_req.start    = w_accept && !w_too_old;
    assign o_div_req.dividend = i_in_data.event_time - r_ws;
    assign o_div_req.divisor  = w_secs;

    // how far the window moves for this event
    always_comb begin
        w_nn   = {25'd0, r_n};
        w_s    = r_quo - w_nn + 32'd1;
        w_d    = 7'd0;
        w_full = 1'b0;
        w_pos  = r_quo[6:0];
        if (r_quo >= w_nn) begin
            if (w_s >= w_nn) begin
                w_d    = r_n;
                w_full = 1'b1;
                w_pos  = 7'd0;
            end else begin
                w_d   = w_s[6:0];
                w_pos = r_n - 7'd1;
            end
        end
    end

    assign w_sum   = r_rdata + r_amount;
    assign w_raddr = f_slot(r_head, r_pos);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = w_sum;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 32'd0;
            end
            S_ZERO: begin
                w_we    = 1'b1;
                w_waddr = f_slot(r_head, r_zoff);
                w_wdata = 32'd0;
            end
            S_ADD: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: if (r_clr == LAST) n_state = S_IDLE;
            S_IDLE: if (w_accept) n_state = w_too_old ? S_DONE : S_DIV;
            S_DIV:  if (i_div_rsp.done) n_state = S_PLAN;
            S_PLAN: n_state = S_MUL;
            S_MUL:  n_state = S_MOVE;
            S_MOVE: n_state = (r_d == 7'd0) ? S_READ : S_ZERO;
            S_ZERO: if (r_zleft == 7'd1) n_state = S_READ;
            S_READ: n_state = S_ADD;
            S_ADD:  n_state = S_DONE;
            S_DONE: if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_clr   <= '0;
            r_ws    <= 32'd0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) r_clr <= r_clr + AW'(1);
            if (r_state == S_MOVE) begin
                r_ws   <= r_full ? r_when : r_ws + 32'(r_prod);
                r_head <= r_full ? r_head : f_slot(r_head, r_d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_when   <= i_in_data.event_time;
                r_amount <= i_in_data.use_default ? 32'd1 : 32'(i_in_data.add_amount);
                r_secs   <= w_secs;
                r_n      <= w_n;
                r_res.status          <= swtb_pkg::ST_TOO_OLD;
                r_res.bucket_index    <= 6'd0;
                r_res.count_after     <= 32'sd0;
                r_res.buckets_dropped <= 7'd0;
                r_res.oldest_start    <= r_ws;
            end
            S_DIV: r_quo <= i_div_rsp.quotient;
            S_PLAN: begin
                r_d    <= w_d;
                r_full <= w_full;
                r_pos  <= w_pos;
            end
            S_MUL: r_prod <= 23'(r_d) * 23'(r_secs);
            S_MOVE: begin
                // new buckets sit at the top of the window after the head moves
                r_zoff  <= r_n - r_d;
                r_zleft <= r_d;
            end
            S_ZERO: begin
                r_zoff  <= r_zoff + 7'd1;
                r_zleft <= r_zleft - 7'd1;
            end
            S_READ: r_slot <= w_raddr;
            S_ADD: begin
                r_res.status          <= swtb_pkg::ST_COUNTED;
                r_res.bucket_index    <= r_pos[5:0];
                r_res.count_after     <= w_sum;
                r_res.buckets_dropped <= r_d;
                r_res.oldest_start    <= r_ws;
            end
            default: begin
            end
        endcase
    end

endmodule
